@@ rtl/core/itda_pkg.sv @@
// -----------------------------------------------------------------------------
// itda_pkg
// Shared types and constants of the integer to decimal ASCII converter.
// -----------------------------------------------------------------------------
package itda_pkg;

  localparam int unsigned ValueWidth   = 32;
  localparam int unsigned CharWidth    = 7;
  localparam int unsigned NumDigits    = 10;
  localparam int unsigned DigitWidth   = 4;
  localparam int unsigned BcdWidth     = NumDigits * DigitWidth;
  localparam int unsigned IdxWidth     = $clog2(NumDigits);
  localparam int unsigned BitsPerCycle = 4;
  localparam int unsigned ConvCycles   = ValueWidth / BitsPerCycle;
  localparam int unsigned CntWidth     = $clog2(ConvCycles);
  localparam int unsigned FifoDepth    = 2;

  localparam logic [CharWidth-1:0] AsciiZero  = 7'd48;
  localparam logic [CharWidth-1:0] AsciiMinus = 7'd45;

  typedef enum logic [1:0] {
    FrIdle,
    FrConv,
    FrPush
  } front_state_e;

  typedef struct packed {
    logic                neg;
    logic [BcdWidth-1:0] bcd;
    logic [IdxWidth-1:0] top_idx;
  } rec_t;

  localparam int unsigned RecWidth = $bits(rec_t);

endpackage

@@ rtl/core/itda_if.sv @@
// -----------------------------------------------------------------------------
// itda_if
// Valid/ready channels carrying input values and output characters.
// -----------------------------------------------------------------------------
interface itda_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [itda_pkg::ValueWidth-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itda_out_if;
  logic                             valid;
  logic                             ready;
  logic [itda_pkg::CharWidth-1:0]   character;
  logic                             last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

@@ rtl/core/itda_front.sv @@
// -----------------------------------------------------------------------------
// itda_front
// Accepts a value, takes its magnitude and converts it to ten BCD digits by
// shift-and-add-3, four bits per cycle, then pushes the record to the queue.
// -----------------------------------------------------------------------------
module itda_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  itda_in_if.sink               in_i,
  output logic                  push_valid_o,
  output itda_pkg::rec_t        push_data_o,
  input  logic                  push_ready_i
);

  itda_pkg::front_state_e state_q, state_d;

  logic                                 neg_q, neg_d;
  logic [itda_pkg::ValueWidth-1:0]      bin_q, bin_d;
  logic [itda_pkg::BcdWidth-1:0]        bcd_q, bcd_d;
  logic [itda_pkg::CntWidth-1:0]        cnt_q, cnt_d;

  logic [itda_pkg::ValueWidth-1:0]      bin_step;
  logic [itda_pkg::BcdWidth-1:0]        bcd_step;
  logic [itda_pkg::IdxWidth-1:0]        top_idx;
  logic                                 accept;

  assign accept = in_i.valid && in_i.ready;

  always_comb begin
    logic [itda_pkg::BcdWidth-1:0]   b;
    logic [itda_pkg::ValueWidth-1:0] m;
    b = bcd_q;
    m = bin_q;
    for (int s = 0; s < itda_pkg::BitsPerCycle; s++) begin
      for (int d = 0; d < itda_pkg::NumDigits; d++) begin
        if (b[d*itda_pkg::DigitWidth +: itda_pkg::DigitWidth] >= 4'd5) begin
          b[d*itda_pkg::DigitWidth +: itda_pkg::DigitWidth] =
            b[d*itda_pkg::DigitWidth +: itda_pkg::DigitWidth] + 4'd3;
        end
      end
      b = {b[itda_pkg::BcdWidth-2:0], m[itda_pkg::ValueWidth-1]};
      m = {m[itda_pkg::ValueWidth-2:0], 1'b0};
    end
    bcd_step = b;
    bin_step = m;
  end

  // find the most significant nonzero digit
  always_comb begin
    top_idx = '0;
    for (int d = 0; d < itda_pkg::NumDigits; d++) begin
      if (bcd_q[d*itda_pkg::DigitWidth +: itda_pkg::DigitWidth] != '0) begin
        top_idx = itda_pkg::IdxWidth'(d);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      itda_pkg::FrIdle: begin
        if (accept) state_d = itda_pkg::FrConv;
      end
      itda_pkg::FrConv: begin
        if (cnt_q == itda_pkg::CntWidth'(itda_pkg::ConvCycles - 1)) state_d = itda_pkg::FrPush;
      end
      itda_pkg::FrPush: begin
        if (push_ready_i) state_d = itda_pkg::FrIdle;
      end
      default: state_d = itda_pkg::FrIdle;
    endcase
  end

  // outputs
  always_comb begin
    in_i.ready   = 1'b0;
    push_valid_o = 1'b0;
    case (state_q)
      itda_pkg::FrIdle: in_i.ready   = 1'b1;
      itda_pkg::FrPush: push_valid_o = 1'b1;
      default: ;
    endcase
  end

  assign push_data_o.neg     = neg_q;
  assign push_data_o.bcd     = bcd_q;
  assign push_data_o.top_idx = top_idx;

  // datapath
  always_comb begin
    neg_d = neg_q;
    bin_d = bin_q;
    bcd_d = bcd_q;
    cnt_d = cnt_q;
    if (accept) begin
      neg_d = in_i.value[itda_pkg::ValueWidth-1];
      bin_d = in_i.value[itda_pkg::ValueWidth-1] ? (itda_pkg::ValueWidth'(0) - in_i.value)
                                                 : in_i.value;
      bcd_d = '0;
      cnt_d = '0;
    end else if (state_q == itda_pkg::FrConv) begin
      bin_d = bin_step;
      bcd_d = bcd_step;
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itda_pkg::FrIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

endmodule

@@ rtl/core/itda_fifo.sv @@
// -----------------------------------------------------------------------------
// itda_fifo
// Small register queue between the converter and the character emitter.
// -----------------------------------------------------------------------------
module itda_fifo #(
  parameter int unsigned Width = itda_pkg::RecWidth,
  parameter int unsigned Depth = itda_pkg::FifoDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  input  logic [Width-1:0] push_data_i,
  output logic             push_ready_o,
  output logic             pop_valid_o,
  output logic [Width-1:0] pop_data_o,
  input  logic             pop_ready_i
);

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);

  logic [Width-1:0]    mem_q [Depth];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                push, pop;

  assign push_ready_o = (cnt_q != CntWidth'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ rtl/core/itda_back.sv @@
// -----------------------------------------------------------------------------
// itda_back
// Takes converted records from the queue and emits the sign and the digits,
// most significant first, through a registered output stage.
// -----------------------------------------------------------------------------
module itda_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  pop_valid_i,
  input  itda_pkg::rec_t        pop_data_i,
  output logic                  pop_ready_o,
  itda_out_if.source            out_o
);

  logic                              active_q, active_d;
  logic                              neg_q, neg_d;
  logic [itda_pkg::BcdWidth-1:0]     bcd_q, bcd_d;
  logic [itda_pkg::IdxWidth-1:0]     idx_q, idx_d;
  logic                              ov_q, ov_d;
  logic [itda_pkg::CharWidth-1:0]    ch_q, ch_d;
  logic                              last_q, last_d;

  logic                              slot_free;
  logic                              pop;
  logic [itda_pkg::DigitWidth-1:0]   digit;

  assign slot_free   = !ov_q || out_o.ready;
  assign pop_ready_o = !active_q;
  assign pop         = pop_valid_i && pop_ready_o;
  assign digit       = bcd_q[{idx_q, 2'b00} +: itda_pkg::DigitWidth];

  assign out_o.valid     = ov_q;
  assign out_o.character = ch_q;
  assign out_o.last      = last_q;

  always_comb begin
    active_d = active_q;
    neg_d    = neg_q;
    bcd_d    = bcd_q;
    idx_d    = idx_q;
    ov_d     = ov_q;
    ch_d     = ch_q;
    last_d   = last_q;
    if (pop) begin
      active_d = 1'b1;
      neg_d    = pop_data_i.neg;
      bcd_d    = pop_data_i.bcd;
      idx_d    = pop_data_i.top_idx;
    end
    if (active_q && slot_free) begin
      ov_d = 1'b1;
      if (neg_q) begin
        ch_d   = itda_pkg::AsciiMinus;
        last_d = 1'b0;
        neg_d  = 1'b0;
      end else begin
        ch_d   = itda_pkg::AsciiZero + itda_pkg::CharWidth'(digit);
        last_d = (idx_q == '0);
        if (idx_q == '0) begin
          active_d = 1'b0;
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      active_q <= active_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    bcd_q  <= bcd_d;
    idx_q  <= idx_d;
    ch_q   <= ch_d;
    last_q <= last_d;
  end

endmodule

@@ rtl/core/int_to_decimal_ascii_core.sv @@
// -----------------------------------------------------------------------------
// int_to_decimal_ascii_core
// Signed 32-bit integer to decimal ASCII text, one character per transfer.
// -----------------------------------------------------------------------------
// Each accepted value produces its decimal text, most significant character
// first: a leading '-' for negative values, no leading zeros, a single '0' for
// zero, and last set on the final character. The converter accepts a value,
// converts it by shift-and-add-3 at four bits per cycle and pushes the
// record into the queue before it accepts the next value; the emitter loads
// each record from the queue once the previous one is sent and then sends
// one character per cycle while the output is ready. The queue between the
// two lets conversion of the next value run while the current one is emitted.
// -----------------------------------------------------------------------------
module int_to_decimal_ascii_core #(
  parameter int unsigned FifoDepth = itda_pkg::FifoDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  itda_in_if.sink    in_i,
  itda_out_if.source out_o
);

  logic           push_valid, push_ready;
  itda_pkg::rec_t push_data;
  logic           pop_valid, pop_ready;
  itda_pkg::rec_t pop_data;

  itda_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  itda_fifo #(
    .Width (itda_pkg::RecWidth),
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_ready_i  (pop_ready)
  );

  itda_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

endmodule

@@ rtl/core/itda_checker.sv @@
// -----------------------------------------------------------------------------
// itda_checker
// Port-level checks of the converter, bound to the top level.
// -----------------------------------------------------------------------------
module itda_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic [itda_pkg::CharWidth-1:0] out_character_i,
  input  logic                           out_last_i
);

  logic out_is_digit;
  assign out_is_digit = (out_character_i >= itda_pkg::AsciiZero) &&
                        (out_character_i <= (itda_pkg::AsciiZero + 7'd9));

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_character_i) &&
                                    $stable(out_last_i))
    else $error("output changed while stalled");

  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_character_i == itda_pkg::AsciiMinus) || out_is_digit)
    else $error("character is neither sign nor digit");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_character_i == itda_pkg::AsciiMinus) |-> !out_last_i)
    else $error("sign marked as last character");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted during conversion");

endmodule

bind int_to_decimal_ascii_core itda_checker u_itda_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_character_i (out_o.character),
  .out_last_i      (out_o.last)
);
